>>> design/assert_macros.svh
// Assertion macros shared by the I2C write transmitter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define OIWT_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clk edge outside reset.
`define OIWT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/oiwt_pkg.sv
// Types and constants of the I2C write transmitter.
`timescale 1ns / 1ps

package oiwt_pkg;

    typedef logic [2:0] mode_t;
    typedef logic [7:0] byte_t;
    typedef logic [1:0] cfg_index_t;

    // Request codes carried on the mode field
    localparam mode_t MODE_TICK   = 3'd0;
    localparam mode_t MODE_CMD    = 3'd1;
    localparam mode_t MODE_DATA   = 3'd2;
    localparam mode_t MODE_PAGE   = 3'd3;
    localparam mode_t MODE_COLUMN = 3'd4;

    // Configuration register indexes
    localparam cfg_index_t CFG_SLAVE_ADDR = 2'd0;
    localparam cfg_index_t CFG_COL_OFFSET = 2'd1;

    localparam byte_t SLAVE_ADDR_RESET = 8'h78;
    localparam byte_t COL_OFFSET_RESET = 8'h02;

    // Control bytes and command prefixes of the display controller
    localparam byte_t CTRL_CMD      = 8'h00;
    localparam byte_t CTRL_DATA     = 8'h40;
    localparam byte_t CMD_COL_HIGH  = 8'h10;
    localparam byte_t CMD_PAGE      = 8'hB0;
    localparam byte_t NIBBLE_MASK   = 8'h0F;

endpackage

>>> design/oled_i2c_write_transmitter.sv
// Top level of the write-only I2C transmitter for an OLED display controller.
`timescale 1ns / 1ps

// Write-only I2C master for an OLED display controller, paced by the request
// stream: a tick request in a transaction changes at most one SCL/SDA pin and
// an idle tick does nothing; a command, data, set page or set column request
// opens a new transaction, taken only while no transaction or queued command
// remains (else accepted low and no effect). A transaction is a start, the
// address byte, a control byte (0x00 command, 0x40 data), the payload byte
// and a stop, each byte MSB first with an unsampled ACK clock: 94 ticks in
// all. Set column sends two command transactions, the second held in a
// one-entry queue. Every request yields one result holding the pin levels,
// busy flag and accepted flag after that request. Throughput is one request
// per clock: the whole pin sequencer step is one pass of logic between the
// state registers and the result register, and a new request is taken
// whenever the result register is empty or being drained in the same cycle.
// The result appears in the cycle after its request is taken. Configuration
// writes are registered and must only be issued while the block is idle.
module oled_i2c_write_transmitter (
    input  logic                 clk,
    input  logic                 rst_n,
    // request channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  oiwt_pkg::mode_t      mode,
    input  oiwt_pkg::byte_t      value,
    // result channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 clock_line,
    output logic                 data_line,
    output logic                 busy_res,
    output logic                 accepted,
    // configuration write port
    input  logic                 cfg_we,
    input  oiwt_pkg::cfg_index_t cfg_index,
    input  oiwt_pkg::byte_t      cfg_data
);

    import oiwt_pkg::*;

`include "assert_macros.svh"

    // Sequencer phases
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_START = 3'd1;
    localparam logic [2:0] PH_BIT   = 3'd2;
    localparam logic [2:0] PH_ACK   = 3'd3;
    localparam logic [2:0] PH_STOPA = 3'd4;
    localparam logic [2:0] PH_STOPB = 3'd5;

    localparam logic [1:0] LAST_STEP  = 2'd3;
    localparam logic [1:0] LAST_BYTE  = 2'd2;
    localparam logic [3:0] BITS_BYTE  = 4'd8;

    // Configuration registers
    byte_t slave_addr_reg;
    byte_t col_offset_reg;

    // Sequencer state
    logic [2:0] phase_reg,     phase_next;
    logic [1:0] step_reg,      step_next;
    logic [3:0] bit_count_reg, bit_count_next;
    logic [1:0] byte_idx_reg,  byte_idx_next;
    byte_t      shift_reg,     shift_next;
    byte_t      control_reg,   control_next;
    byte_t      payload_reg,   payload_next;
    byte_t      queued_cmd_reg, queued_cmd_next;
    logic       queued_vld_reg, queued_vld_next;
    logic       scl_reg,       scl_next;
    logic       sda_reg,       sda_next;

    // Result register
    logic       out_valid_reg, out_valid_next;
    logic       accepted_reg,  accepted_next;

    logic       in_fire;
    logic       idle;
    logic [1:0] load_idx;
    logic       do_load;
    byte_t      column_sum;

    // Take a request whenever the result slot is free or drains this cycle
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign idle     = (phase_reg == PH_IDLE) && !queued_vld_reg;

    assign column_sum = value + col_offset_reg;

    // The state only moves on an accepted request, so it is the result payload
    assign out_valid  = out_valid_reg;
    assign clock_line = scl_reg;
    assign data_line  = sda_reg;
    assign busy_res   = (phase_reg != PH_IDLE) || queued_vld_reg;
    assign accepted   = accepted_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        step_next       = step_reg;
        bit_count_next  = bit_count_reg;
        byte_idx_next   = byte_idx_reg;
        shift_next      = shift_reg;
        control_next    = control_reg;
        payload_next    = payload_reg;
        queued_cmd_next = queued_cmd_reg;
        queued_vld_next = queued_vld_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        accepted_next   = accepted_reg;
        do_load         = 1'b0;
        load_idx        = 2'd0;

        if (in_fire)
        begin
            accepted_next = 1'b0;
            if (mode == MODE_TICK)
            begin
                case (phase_reg)
                    PH_IDLE:
                    begin
                        phase_next = PH_IDLE;
                    end
                    PH_START:
                    begin
                        case (step_reg)
                            2'd0:    sda_next = 1'b1;
                            2'd1:    scl_next = 1'b1;
                            2'd2:    sda_next = 1'b0;
                            default: scl_next = 1'b0;
                        endcase
                        if (step_reg == LAST_STEP)
                        begin
                            do_load  = 1'b1;
                            load_idx = 2'd0;
                        end
                        else
                        begin
                            step_next = step_reg + 2'd1;
                        end
                    end
                    PH_BIT:
                    begin
                        if (step_reg == 2'd0)
                        begin
                            scl_next  = 1'b0;
                            step_next = 2'd1;
                        end
                        else if (step_reg == 2'd1)
                        begin
                            // present the MSB, then shift it out
                            sda_next   = shift_reg[7];
                            shift_next = {shift_reg[6:0], 1'b0};
                            step_next  = 2'd2;
                        end
                        else
                        begin
                            scl_next       = 1'b1;
                            step_next      = 2'd0;
                            bit_count_next = bit_count_reg + 4'd1;
                            if (bit_count_next >= BITS_BYTE)
                            begin
                                bit_count_next = 4'd0;
                                phase_next     = PH_ACK;
                            end
                        end
                    end
                    PH_ACK:
                    begin
                        case (step_reg)
                            2'd0:    scl_next = 1'b0;
                            2'd1:    sda_next = 1'b1;
                            2'd2:    scl_next = 1'b1;
                            default: scl_next = 1'b0;
                        endcase
                        if (step_reg == LAST_STEP)
                        begin
                            if (byte_idx_reg >= LAST_BYTE)
                            begin
                                phase_next = PH_STOPA;
                                step_next  = 2'd0;
                            end
                            else
                            begin
                                do_load  = 1'b1;
                                load_idx = byte_idx_reg + 2'd1;
                            end
                        end
                        else
                        begin
                            step_next = step_reg + 2'd1;
                        end
                    end
                    PH_STOPA:
                    begin
                        case (step_reg)
                            2'd0:    sda_next = 1'b0;
                            2'd1:    scl_next = 1'b1;
                            2'd2:    sda_next = 1'b1;
                            default: scl_next = 1'b1;
                        endcase
                        if (step_reg == LAST_STEP)
                        begin
                            phase_next = PH_STOPB;
                            step_next  = 2'd0;
                        end
                        else
                        begin
                            step_next = step_reg + 2'd1;
                        end
                    end
                    PH_STOPB:
                    begin
                        if (step_reg == 2'd0)
                        begin
                            scl_next  = 1'b0;
                            step_next = 2'd1;
                        end
                        else
                        begin
                            sda_next      = 1'b0;
                            step_next     = 2'd0;
                            byte_idx_next = 2'd0;
                            phase_next    = PH_IDLE;
                            // launch the queued second column command
                            if (queued_vld_reg)
                            begin
                                queued_vld_next = 1'b0;
                                control_next    = CTRL_CMD;
                                payload_next    = queued_cmd_reg;
                                phase_next      = PH_START;
                                bit_count_next  = 4'd0;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            else if ((mode inside {[MODE_CMD:MODE_COLUMN]}) && idle)
            begin
                accepted_next  = 1'b1;
                phase_next     = PH_START;
                step_next      = 2'd0;
                bit_count_next = 4'd0;
                byte_idx_next  = 2'd0;
                control_next   = CTRL_CMD;
                case (mode)
                    MODE_CMD:
                    begin
                        payload_next = value;
                    end
                    MODE_DATA:
                    begin
                        control_next = CTRL_DATA;
                        payload_next = value;
                    end
                    MODE_PAGE:
                    begin
                        payload_next = CMD_PAGE | (value & NIBBLE_MASK);
                    end
                    default:
                    begin
                        payload_next    = CMD_COL_HIGH | {4'd0, column_sum[7:4]};
                        queued_cmd_next = column_sum & NIBBLE_MASK;
                        queued_vld_next = 1'b1;
                    end
                endcase
            end
        end

        // Load the next byte into the shifter and start its bits
        if (do_load)
        begin
            byte_idx_next  = load_idx;
            bit_count_next = 4'd0;
            step_next      = 2'd0;
            phase_next     = PH_BIT;
            case (load_idx)
                2'd0:    shift_next = slave_addr_reg;
                2'd1:    shift_next = control_reg;
                default: shift_next = payload_reg;
            endcase
        end
    end

    // Hold the result until taken; refill in the same cycle it drains
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_addr_reg <= SLAVE_ADDR_RESET;
            col_offset_reg <= COL_OFFSET_RESET;
            phase_reg      <= PH_IDLE;
            step_reg       <= 2'd0;
            bit_count_reg  <= 4'd0;
            byte_idx_reg   <= 2'd0;
            shift_reg      <= '0;
            control_reg    <= '0;
            payload_reg    <= '0;
            queued_cmd_reg <= '0;
            queued_vld_reg <= 1'b0;
            scl_reg        <= 1'b0;
            sda_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            accepted_reg   <= 1'b0;
        end
        else
        begin
            // drop writes to indexes beyond the register list
            if (cfg_we && (cfg_index == CFG_SLAVE_ADDR))
            begin
                slave_addr_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == CFG_COL_OFFSET))
            begin
                col_offset_reg <= cfg_data;
            end
            phase_reg      <= phase_next;
            step_reg       <= step_next;
            bit_count_reg  <= bit_count_next;
            byte_idx_reg   <= byte_idx_next;
            shift_reg      <= shift_next;
            control_reg    <= control_next;
            payload_reg    <= payload_next;
            queued_cmd_reg <= queued_cmd_next;
            queued_vld_reg <= queued_vld_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            out_valid_reg  <= out_valid_next;
            accepted_reg   <= accepted_next;
        end
    end

    `OIWT_ASSERT_IMPLY(a_queue_has_txn, queued_vld_reg, phase_reg != PH_IDLE,
        "queued command without an active transaction")
    `OIWT_ASSERT_IMPLY(a_bit_count_range, 1'b1, bit_count_reg < BITS_BYTE,
        "bit counter ran past one byte")
    `OIWT_ASSERT_IMPLY(a_accept_busy, out_valid_reg && accepted_reg, busy_res,
        "accepted request left the sequencer idle")
    `OIWT_ASSERT_NEXT(a_idle_request_taken,
        in_fire && idle && (mode == MODE_CMD || mode == MODE_DATA),
        out_valid_reg && accepted_reg && (phase_reg == PH_START),
        "request while idle was not taken")

endmodule
